>>> hdl/ofa_pkg.sv
// Shared types and constants for the orthonormal frame block.
// Used by ofa_norm and by the top level orthonormal_frame_from_axis_unit.
package ofa_pkg;

    // One in Q4.60, the scale of a product of two Q2.30 values.
    localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

    // Coordinate axis chosen as the seed of the second vector.
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    // Sideband that travels with an item through a normalising unit.
    typedef struct packed {
        logic            deg;
        sel_t            sel;
        logic [2:0][31:0] f;
    } tag_t;

endpackage

>>> hdl/orthonormal_frame_from_axis_unit.sv
// Top level of the orthonormal frame block: axis in, three unit vectors out.
// Depends on ofa_pkg and two instances of the normalising pipeline ofa_norm.
//
// Usage:
// The input channel (s_valid, s_ready) carries one axis vector per beat as
// three signed Q16.16 components. The result channel (m_valid, m_ready)
// carries one frame per beat: the normalised axis, a unit vector
// perpendicular to it and their cross product, all signed Q2.30, plus a
// degenerate flag that is set, with all vectors zero, for a zero axis.
// Throughput is one beat per cycle while m_ready does not stall the
// pipeline: every stage is a register and each normalising pipeline has
// a 32 stage square root and a 31 stage divider.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline halts and s_ready falls; nothing is lost or repeated, and it
// moves on as soon as m_ready returns. Bubbles travel as empty stages.
// A synchronous reset (aresetn low) clears every valid bit; the pipeline
// is then empty and ready for input on the next cycle.
module orthonormal_frame_from_axis_unit
    import ofa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_axis_x,
    input  logic signed [31:0] s_axis_y,
    input  logic signed [31:0] s_axis_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_first_x,
    output logic signed [31:0] m_first_y,
    output logic signed [31:0] m_first_z,
    output logic signed [31:0] m_second_x,
    output logic signed [31:0] m_second_y,
    output logic signed [31:0] m_second_z,
    output logic signed [31:0] m_third_x,
    output logic signed [31:0] m_third_y,
    output logic signed [31:0] m_third_z,
    output logic               m_degenerate
);

    // Round a Q60 value to Q30, half away from zero.
    function automatic logic signed [32:0] rnd_q30(logic signed [63:0] v);
        logic [63:0] mg;
        logic [63:0] r;
        mg = v[63] ? 64'(-v) : 64'(v);
        r  = (mg + 64'h2000_0000) >> 30;
        return v[63] ? -33'(r) : 33'(r);
    endfunction

    logic en;
    logic e_v_reg;

    // The pipeline advances unless a result waits on a stalled receiver.
    // No beat is taken while reset is held.
    assign en      = !e_v_reg || m_ready;
    assign s_ready = en && aresetn;

    // Seed axis choice: smallest magnitude, ties to x, then y.
    logic [31:0] ab_x, ab_y, ab_z;
    tag_t        in_tag;
    assign ab_x = s_axis_x[31] ? 32'(-s_axis_x) : 32'(s_axis_x);
    assign ab_y = s_axis_y[31] ? 32'(-s_axis_y) : 32'(s_axis_y);
    assign ab_z = s_axis_z[31] ? 32'(-s_axis_z) : 32'(s_axis_z);

    always_comb begin
        in_tag = '0;
        priority if (ab_x <= ab_y && ab_x <= ab_z) begin
            in_tag.sel = SEL_X;
        end else if (ab_y <= ab_z) begin
            in_tag.sel = SEL_Y;
        end else begin
            in_tag.sel = SEL_Z;
        end
    end

    logic [2:0][32:0] in_c;
    assign in_c[0] = 33'(s_axis_x);
    assign in_c[1] = 33'(s_axis_y);
    assign in_c[2] = 33'(s_axis_z);

    // First vector: the normalised axis.
    logic             n1_valid;
    logic [2:0][31:0] n1_o;
    logic             n1_zero;
    tag_t             n1_tag;

    ofa_norm u_norm_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_c      (in_c),
        .in_tag    (in_tag),
        .out_valid (n1_valid),
        .out_o     (n1_o),
        .out_zero  (n1_zero),
        .out_tag   (n1_tag)
    );

    // Projection products f_j * f_i.
    logic signed [31:0] f_sel;
    always_comb begin
        unique case (n1_tag.sel)
            SEL_X:   f_sel = n1_o[0];
            SEL_Y:   f_sel = n1_o[1];
            SEL_Z:   f_sel = n1_o[2];
            default: f_sel = n1_o[0];
        endcase
    end

    logic             a_v_reg, b_v_reg, c_v_reg;
    logic [2:0][63:0] pa_reg, vb_reg;
    logic [2:0][32:0] wc_reg;
    tag_t             a_tag_reg, b_tag_reg, c_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= n1_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    // Remainder of the seed axis after the projection, rounded to Q30.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= 64'(f_sel * $signed(n1_o[i]));
            end
            a_tag_reg     <= '{deg: n1_zero, sel: n1_tag.sel, f: n1_o};

            for (int i = 0; i < 3; i++) begin
                vb_reg[i] <= ((sel_t'(2'(i)) == a_tag_reg.sel) ? ONE_Q60 : 64'sd0)
                             - $signed(pa_reg[i]);
            end
            b_tag_reg     <= a_tag_reg;

            for (int i = 0; i < 3; i++) wc_reg[i] <= rnd_q30($signed(vb_reg[i]));
            c_tag_reg     <= b_tag_reg;
        end
    end

    // Second vector: the remainder normalised.
    logic             n2_valid;
    logic [2:0][31:0] n2_o;
    logic             n2_zero;
    tag_t             n2_tag;

    ofa_norm u_norm_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_v_reg),
        .in_c      (wc_reg),
        .in_tag    (c_tag_reg),
        .out_valid (n2_valid),
        .out_o     (n2_o),
        .out_zero  (n2_zero),
        .out_tag   (n2_tag)
    );

    // Cross product: six products, then differences, then round and saturate.
    logic             cp_v_reg, d_v_reg;
    logic [5:0][63:0] cp_reg;
    logic [2:0][63:0] d_reg;
    logic [2:0][31:0] cp_f_reg, cp_s_reg, d_f_reg, d_s_reg;
    logic             cp_deg_reg, d_deg_reg;
    logic [2:0][31:0] e_f_reg, e_s_reg, e_t_reg;
    logic             e_deg_reg;
    logic [2:0][32:0] t_rnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_v_reg <= 1'b0;
            d_v_reg  <= 1'b0;
            e_v_reg  <= 1'b0;
        end else if (en) begin
            cp_v_reg <= n2_valid;
            d_v_reg  <= cp_v_reg;
            e_v_reg  <= d_v_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) t_rnd[i] = rnd_q30($signed(d_reg[i]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cp_reg[0]  <= 64'($signed(n2_tag.f[1]) * $signed(n2_o[2]));
            cp_reg[1]  <= 64'($signed(n2_tag.f[2]) * $signed(n2_o[1]));
            cp_reg[2]  <= 64'($signed(n2_tag.f[2]) * $signed(n2_o[0]));
            cp_reg[3]  <= 64'($signed(n2_tag.f[0]) * $signed(n2_o[2]));
            cp_reg[4]  <= 64'($signed(n2_tag.f[0]) * $signed(n2_o[1]));
            cp_reg[5]  <= 64'($signed(n2_tag.f[1]) * $signed(n2_o[0]));
            cp_f_reg   <= n2_tag.f;
            cp_s_reg   <= n2_zero ? '0 : n2_o;
            cp_deg_reg <= n2_tag.deg;

            d_reg[0]   <= cp_reg[0] - cp_reg[1];
            d_reg[1]   <= cp_reg[2] - cp_reg[3];
            d_reg[2]   <= cp_reg[4] - cp_reg[5];
            d_f_reg    <= cp_f_reg;
            d_s_reg    <= cp_s_reg;
            d_deg_reg  <= cp_deg_reg;

            // A degenerate axis clears the whole frame.
            for (int i = 0; i < 3; i++) begin
                if (d_deg_reg) begin
                    e_t_reg[i] <= 32'd0;
                end else if (!t_rnd[i][32] && t_rnd[i][31]) begin
                    e_t_reg[i] <= 32'h7FFF_FFFF;
                end else begin
                    e_t_reg[i] <= t_rnd[i][31:0];
                end
            end
            e_f_reg   <= d_deg_reg ? '0 : d_f_reg;
            e_s_reg   <= d_deg_reg ? '0 : d_s_reg;
            e_deg_reg <= d_deg_reg;
        end
    end

    assign m_valid      = e_v_reg;
    assign m_first_x    = e_f_reg[0];
    assign m_first_y    = e_f_reg[1];
    assign m_first_z    = e_f_reg[2];
    assign m_second_x   = e_s_reg[0];
    assign m_second_y   = e_s_reg[1];
    assign m_second_z   = e_s_reg[2];
    assign m_third_x    = e_t_reg[0];
    assign m_third_y    = e_t_reg[1];
    assign m_third_z    = e_t_reg[2];
    assign m_degenerate = e_deg_reg;

    // A degenerate result carries an all zero frame.
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |->
            (m_first_x == 0 && m_first_y == 0 && m_first_z == 0 &&
             m_second_x == 0 && m_second_y == 0 && m_second_z == 0 &&
             m_third_x == 0 && m_third_y == 0 && m_third_z == 0))
        else $error("degenerate result with a non-zero vector");

    // The x components of the first and second vectors never exceed one in magnitude.
    a_first_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_degenerate) |->
            ($signed(m_first_x) <= 32'sh4000_0000 && $signed(m_first_x) >= -32'sh4000_0000 &&
             $signed(m_second_x) <= 32'sh4000_0000 && $signed(m_second_x) >= -32'sh4000_0000))
        else $error("normalised component beyond one");

    // The perpendicular vector of a valid axis is never all zero.
    a_second_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_degenerate) |->
            (m_second_x != 0 || m_second_y != 0 || m_second_z != 0))
        else $error("perpendicular vector vanished");

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule

>>> hdl/ofa_norm.sv
// Pipelined normalisation of a three component vector to unit length in Q2.30.
// Depends on ofa_pkg for the sideband type that travels with each item.
module ofa_norm
    import ofa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][32:0] in_c,
    input  tag_t             in_tag,
    output logic             out_valid,
    output logic [2:0][31:0] out_o,
    output logic             out_zero,
    output tag_t             out_tag
);

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][31:0] u;
        tag_t             tag;
    } nrm_pl_t;

    // Left shift that brings the largest magnitude to at least 2^30.
    function automatic logic [4:0] shift_for(logic [31:0] m);
        logic [4:0] k;
        k = 5'd0;
        for (int b = 0; b < 30; b++) begin
            if (m[b]) k = 5'(30 - b);
        end
        // A magnitude already at or above 2^30 needs no shift.
        if (m[31] || m[30]) k = 5'd0;
        return k;
    endfunction

    // Stage 0: magnitudes and signs.
    logic [2:0][31:0] mag_c;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_c[i] = in_c[i][32] ? 32'(-in_c[i]) : in_c[i][31:0];
        end
    end

    logic             v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][31:0] mg0_reg, mg1_reg, mg2_reg, u3_reg, u4_reg;
    logic [2:0]       neg0_reg, neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    tag_t             tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [31:0]      m1_reg;
    logic [4:0]       k2_reg;
    logic             zero2_reg, zero3_reg, zero4_reg;
    logic [2:0][63:0] sq4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stages 0 to 4: magnitudes, maximum, shift count, shift, squares.
    always_ff @(posedge aclk) begin
        if (en) begin
            mg0_reg  <= mag_c;
            for (int i = 0; i < 3; i++) neg0_reg[i] <= in_c[i][32];
            tag0_reg <= in_tag;

            m1_reg   <= (mg0_reg[0] >= mg0_reg[1]) ?
                        ((mg0_reg[0] >= mg0_reg[2]) ? mg0_reg[0] : mg0_reg[2]) :
                        ((mg0_reg[1] >= mg0_reg[2]) ? mg0_reg[1] : mg0_reg[2]);
            mg1_reg  <= mg0_reg;
            neg1_reg <= neg0_reg;
            tag1_reg <= tag0_reg;

            k2_reg    <= shift_for(m1_reg);
            zero2_reg <= (m1_reg == 32'd0);
            mg2_reg   <= mg1_reg;
            neg2_reg  <= neg1_reg;
            tag2_reg  <= tag1_reg;

            for (int i = 0; i < 3; i++) u3_reg[i] <= mg2_reg[i] << k2_reg;
            zero3_reg <= zero2_reg;
            neg3_reg  <= neg2_reg;
            tag3_reg  <= tag2_reg;

            for (int i = 0; i < 3; i++) sq4_reg[i] <= 64'(u3_reg[i]) * 64'(u3_reg[i]);
            u4_reg    <= u3_reg;
            zero4_reg <= zero3_reg;
            neg4_reg  <= neg3_reg;
            tag4_reg  <= tag3_reg;
        end
    end

    // Stage 5: sum of squares, which seeds the root pipeline.
    logic [63:0] sq_n_reg [0:32];
    logic [63:0] sq_r_reg [0:32];
    nrm_pl_t     sq_p_reg [0:32];
    logic        sq_v_reg [0:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_n_reg[0] <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
            sq_r_reg[0] <= 64'd0;
            sq_p_reg[0] <= '{zero: zero4_reg, neg: neg4_reg, u: u4_reg, tag: tag4_reg};
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar s = 0; s < 32; s++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
        logic [63:0] trial;
        assign trial = sq_r_reg[s] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[s+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[s+1] <= sq_v_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (sq_n_reg[s] >= trial) begin
                    sq_n_reg[s+1] <= sq_n_reg[s] - trial;
                    sq_r_reg[s+1] <= (sq_r_reg[s] >> 1) + BIT;
                end else begin
                    sq_n_reg[s+1] <= sq_n_reg[s];
                    sq_r_reg[s+1] <= sq_r_reg[s] >> 1;
                end
                sq_p_reg[s+1] <= sq_p_reg[s];
            end
        end
    end

    // Dividend set up: u shifted to Q30 plus half the length for rounding.
    logic [2:0][62:0] dr_reg [0:31];
    logic [2:0][30:0] dq_reg [0:31];
    logic [31:0]      dl_reg [0:31];
    nrm_pl_t          dp_reg [0:31];
    logic             dv_reg [0:31];
    logic [31:0]      root_len;

    assign root_len = sq_r_reg[32][31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= sq_v_reg[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= (63'(sq_p_reg[32].u[i]) << 30) + 63'(root_len >> 1);
            end
            dq_reg[0] <= '0;
            dl_reg[0] <= root_len;
            dp_reg[0] <= sq_p_reg[32];
        end
    end

    // Restoring division, one quotient bit per stage in each of three lanes.
    for (genvar d = 0; d < 31; d++) begin : g_div
        localparam int B = 30 - d;
        logic [62:0] trial;
        assign trial = 63'(dl_reg[d]) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[d+1] <= 1'b0;
            end else if (en) begin
                dv_reg[d+1] <= dv_reg[d];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (dr_reg[d][i] >= trial) begin
                        dr_reg[d+1][i]    <= dr_reg[d][i] - trial;
                        dq_reg[d+1][i]    <= dq_reg[d][i] | (31'd1 << B);
                    end else begin
                        dr_reg[d+1][i]    <= dr_reg[d][i];
                        dq_reg[d+1][i]    <= dq_reg[d][i];
                    end
                end
                dl_reg[d+1] <= dl_reg[d];
                dp_reg[d+1] <= dp_reg[d];
            end
        end
    end

    // Final stage: apply signs; a zero vector gives zero.
    logic             ov_reg;
    logic [2:0][31:0] oo_reg;
    logic             oz_reg;
    tag_t             ot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_reg[31];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dp_reg[31].zero) begin
                    oo_reg[i] <= 32'd0;
                end else if (dp_reg[31].neg[i]) begin
                    oo_reg[i] <= -32'(dq_reg[31][i]);
                end else begin
                    oo_reg[i] <= 32'(dq_reg[31][i]);
                end
            end
            oz_reg <= dp_reg[31].zero;
            ot_reg <= dp_reg[31].tag;
        end
    end

    assign out_valid = ov_reg;
    assign out_o     = oo_reg;
    assign out_zero  = oz_reg;
    assign out_tag   = ot_reg;

endmodule
